FILE: sv/vfps_pkg.sv
// Package for the frame present scheduler: field widths, register and command
// codes, list codes and the sequencer's control program.
// No dependencies.
package vfps_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int TIME_W         = 63;
  localparam int VBK_W          = 32;
  localparam int MARGIN_W       = 3;
  localparam int CMD_W          = 2;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 63;
  localparam int SLOT_OUT_W     = 3;
  localparam int COUNT_OUT_W    = 4;
  localparam int LIST_N         = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MARGIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_DURATION  = 1'd1;

  localparam logic [MARGIN_W-1:0] MARGIN_RST   = 3'd2;
  localparam logic [TIME_W-1:0]   DURATION_RST = '1;

  localparam logic [CMD_W-1:0] CMD_PROCESS  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DECODED  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RENDERED = 2'd2;

  typedef logic [1:0] list_t;
  localparam list_t L_FREE  = 2'd0;
  localparam list_t L_READY = 2'd1;
  localparam list_t L_BUSY  = 2'd2;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t ST_DISPATCH = 5'd0;
  localparam step_t ST_B0       = 5'd1;
  localparam step_t ST_B1       = 5'd2;
  localparam step_t ST_B2       = 5'd3;
  localparam step_t ST_B3       = 5'd4;
  localparam step_t ST_D0       = 5'd5;
  localparam step_t ST_D1       = 5'd6;
  localparam step_t ST_D2       = 5'd7;
  localparam step_t ST_D3       = 5'd8;
  localparam step_t ST_P0       = 5'd9;
  localparam step_t ST_P1       = 5'd10;
  localparam step_t ST_P2       = 5'd11;
  localparam step_t ST_C0       = 5'd12;
  localparam step_t ST_C1       = 5'd13;
  localparam step_t ST_G0       = 5'd14;
  localparam step_t ST_G1       = 5'd15;
  localparam step_t ST_FIN      = 5'd16;

  // Sequencing: how the step counter moves on
  typedef logic [2:0] seq_t;
  localparam seq_t SEQ_NEXT     = 3'd0;
  localparam seq_t SEQ_JMP      = 3'd1;
  localparam seq_t SEQ_JCOND    = 3'd2;
  localparam seq_t SEQ_DISPATCH = 3'd3;
  localparam seq_t SEQ_END      = 3'd4;

  // Jump conditions
  typedef logic [2:0] cond_t;
  localparam cond_t C_NONE      = 3'd0;
  localparam cond_t C_BUSY_STOP = 3'd1;
  localparam cond_t C_REL_STOP  = 3'd2;
  localparam cond_t C_RDY_STOP  = 3'd3;
  localparam cond_t C_LATE      = 3'd4;
  localparam cond_t C_RDY_EMPTY = 3'd5;
  localparam cond_t C_NO_FREE   = 3'd6;
  localparam cond_t C_NO_CUR    = 3'd7;

  // Memory read address select
  typedef logic [2:0] addr_t;
  localparam addr_t A_NONE       = 3'd0;
  localparam addr_t A_BUSY_HEAD  = 3'd1;
  localparam addr_t A_READY_HEAD = 3'd2;
  localparam addr_t A_FREE_HEAD  = 3'd3;
  localparam addr_t A_LINK       = 3'd4;

  // Datapath operations
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE    = 3'd0;
  localparam op_t OP_RELEASE = 3'd1;
  localparam op_t OP_DROP    = 3'd2;
  localparam op_t OP_PRESENT = 3'd3;
  localparam op_t OP_ACCEPT  = 3'd4;
  localparam op_t OP_STAMP   = 3'd5;
  localparam op_t OP_FINISH  = 3'd6;

  typedef struct packed {
    seq_t  seq;
    cond_t cond;
    addr_t addr;
    op_t   op;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    case (step)
      ST_DISPATCH: w = '{SEQ_DISPATCH, C_NONE,      A_NONE,       OP_NONE,    ST_FIN};
      // release busy heads whose successor has aged enough
      ST_B0:       w = '{SEQ_JCOND,    C_BUSY_STOP, A_BUSY_HEAD,  OP_NONE,    ST_D0};
      ST_B1:       w = '{SEQ_NEXT,     C_NONE,      A_LINK,       OP_NONE,    ST_FIN};
      ST_B2:       w = '{SEQ_JCOND,    C_REL_STOP,  A_NONE,       OP_NONE,    ST_D0};
      ST_B3:       w = '{SEQ_JMP,      C_NONE,      A_NONE,       OP_RELEASE, ST_B0};
      // drop ready heads whose successor is already due
      ST_D0:       w = '{SEQ_JCOND,    C_RDY_STOP,  A_READY_HEAD, OP_NONE,    ST_P0};
      ST_D1:       w = '{SEQ_NEXT,     C_NONE,      A_LINK,       OP_NONE,    ST_FIN};
      ST_D2:       w = '{SEQ_JCOND,    C_LATE,      A_NONE,       OP_NONE,    ST_P0};
      ST_D3:       w = '{SEQ_JMP,      C_NONE,      A_NONE,       OP_DROP,    ST_D0};
      // present a due ready head
      ST_P0:       w = '{SEQ_JCOND,    C_RDY_EMPTY, A_READY_HEAD, OP_NONE,    ST_FIN};
      ST_P1:       w = '{SEQ_JCOND,    C_LATE,      A_NONE,       OP_NONE,    ST_FIN};
      ST_P2:       w = '{SEQ_JMP,      C_NONE,      A_NONE,       OP_PRESENT, ST_FIN};
      // decoded frame
      ST_C0:       w = '{SEQ_JCOND,    C_NO_FREE,   A_FREE_HEAD,  OP_NONE,    ST_FIN};
      ST_C1:       w = '{SEQ_JMP,      C_NONE,      A_NONE,       OP_ACCEPT,  ST_FIN};
      // rendered frame
      ST_G0:       w = '{SEQ_JCOND,    C_NO_CUR,    A_NONE,       OP_NONE,    ST_FIN};
      ST_G1:       w = '{SEQ_NEXT,     C_NONE,      A_NONE,       OP_STAMP,   ST_FIN};
      ST_FIN:      w = '{SEQ_END,      C_NONE,      A_NONE,       OP_FINISH,  ST_DISPATCH};
      default:     w = '{SEQ_END,      C_NONE,      A_NONE,       OP_FINISH,  ST_DISPATCH};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/video_frame_present_scheduler.sv
// Frame present scheduler: microcoded sequencer over three linked slot lists.
// Depends on vfps_pkg (codes, widths and the control program).

// A word is taken when start is high and busy is low; busy then stays high
// until the result word has been produced. The result is shown for exactly
// one cycle with out_valid high and the receiver cannot hold it off. The
// work is a short control program, one step per cycle, whose length depends
// on the command and, for a process command, on the number of released and
// dropped frames. The release and drop walks go one list entry per four
// steps because each entry needs a link read and then a stamp read from the
// slot memories, each with a registered read port. No new word is taken
// during the program. Configuration writes through cfg_we are meant for the
// idle block and take effect at once. After reset the slots 0 to
// SLOT_COUNT-1 sit in order in the free list; no clearing pass is needed.
module video_frame_present_scheduler
  import vfps_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [CMD_W-1:0]        in_command,
  input  logic [TIME_W-1:0]       in_current_time,
  input  logic [VBK_W-1:0]        in_vblank_count,
  input  logic [TIME_W-1:0]       in_frame_time,
  output logic                    out_valid,
  output logic                    out_present_valid,
  output logic [SLOT_OUT_W-1:0]   out_present_slot,
  output logic [COUNT_OUT_W-1:0]  out_dropped_count,
  output logic [COUNT_OUT_W-1:0]  out_released_count,
  output logic                    out_accepted,
  output logic                    out_free_available,
  output logic [SLOT_OUT_W-1:0]   out_free_slot,
  output logic [COUNT_OUT_W-1:0]  out_ready_count,
  output logic [COUNT_OUT_W-1:0]  out_busy_count,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int SW    = $clog2(SLOT_COUNT);
  localparam int LW    = $clog2(SLOT_COUNT + 1);
  localparam int SUM_W = LW + 2;

  // Configuration
  logic [MARGIN_W-1:0] margin_r;
  logic [TIME_W-1:0]   duration_r;

  // Sequencer
  logic   run_r;
  step_t  step_r, step_nxt;
  logic   out_valid_r;
  ucode_t uw;
  logic   cond_hit;

  // Latched input word
  logic [CMD_W-1:0]  cmd_r;
  logic [TIME_W-1:0] now_r;
  logic [VBK_W-1:0]  vb_r;
  logic [TIME_W-1:0] ftime_r;

  // List descriptors
  logic [SW-1:0]     head_r [LIST_N];
  logic [SW-1:0]     tail_r [LIST_N];
  logic [LW-1:0]     len_r  [LIST_N];
  logic [LIST_N-1:0] ne_r;
  logic [SW-1:0]     head_nxt [LIST_N];
  logic [SW-1:0]     tail_nxt [LIST_N];
  logic [LW-1:0]     len_nxt  [LIST_N];
  logic [LIST_N-1:0] ne_nxt;

  // Per-slot link flags and written marks
  logic [SLOT_COUNT-1:0] lv_r, lv_nxt;
  logic [SLOT_COUNT-1:0] lnk_wr_r;
  logic [SLOT_COUNT-1:0] vbk_wr_r;

  // Current frame
  logic [SW-1:0] cur_r;
  logic          cur_v_r;

  // Per-word result accumulators
  logic                   pvalid_r;
  logic [SW-1:0]          pslot_r;
  logic [COUNT_OUT_W-1:0] drop_r;
  logic [COUNT_OUT_W-1:0] rel_r;
  logic                   acc_r;

  // Slot memories and their registered read ports
  logic [SW-1:0]     link_mem [SLOT_COUNT];
  logic [TIME_W-1:0] time_mem [SLOT_COUNT];
  logic [VBK_W-1:0]  vbk_mem  [SLOT_COUNT];
  logic [SW-1:0]     link_q_r;
  logic              link_wr_q_r;
  logic [SW-1:0]     link_addr_q_r;
  logic [TIME_W-1:0] time_rd_r;
  logic [VBK_W-1:0]  vbk_q_r;
  logic              vbk_wr_q_r;

  logic [SW-1:0]    rd_addr;
  logic             ld_link, ld_data;
  logic [SW-1:0]    link_rd;
  logic [VBK_W-1:0] vbk_rd;
  logic [VBK_W-1:0] rel_limit;

  // Move of one slot from the head of one list to the tail of another
  logic          mv_en;
  list_t         src, dst;
  logic [SW-1:0] mv_slot, dst_tail;
  logic          dst_ne;
  logic          start_acc;
  logic          link_we, time_we, vbk_we;

  function automatic logic [SW-1:0] slot_inc(logic [SW-1:0] a);
    return (a == SW'(SLOT_COUNT - 1)) ? '0 : a + 1'b1;
  endfunction

  assign start_acc = start && !run_r;
  assign uw        = ucode_rom(step_r);

  // Unwritten link entries still hold the reset chain; unwritten stamps read zero.
  assign link_rd   = link_wr_q_r ? link_q_r : slot_inc(link_addr_q_r);
  assign vbk_rd    = vbk_wr_q_r ? vbk_q_r : '0;
  assign rel_limit = vbk_rd + VBK_W'(margin_r);

  // Read address for all three slot memories
  always_comb begin
    case (uw.addr)
      A_BUSY_HEAD:  rd_addr = head_r[L_BUSY];
      A_READY_HEAD: rd_addr = head_r[L_READY];
      A_FREE_HEAD:  rd_addr = head_r[L_FREE];
      A_LINK:       rd_addr = link_rd;
      default:      rd_addr = '0;
    endcase
  end

  // Hold the link read while the next step follows it into the stamp memories.
  assign ld_link = run_r && (uw.addr inside {A_BUSY_HEAD, A_READY_HEAD, A_FREE_HEAD});
  assign ld_data = run_r && (uw.addr != A_NONE);

  // Jump conditions
  always_comb begin
    case (uw.cond)
      C_BUSY_STOP: cond_hit = !ne_r[L_BUSY] || !lv_r[head_r[L_BUSY]];
      C_REL_STOP:  cond_hit = !(rel_limit < vb_r);
      C_RDY_STOP:  cond_hit = !ne_r[L_READY] || !lv_r[head_r[L_READY]];
      C_LATE:      cond_hit = time_rd_r > now_r;
      C_RDY_EMPTY: cond_hit = !ne_r[L_READY];
      C_NO_FREE:   cond_hit = !ne_r[L_FREE] || !(ftime_r < duration_r);
      C_NO_CUR:    cond_hit = !cur_v_r;
      default:     cond_hit = 1'b0;
    endcase
  end

  // Step counter: advance, jump, jump on a condition, branch on the command, or hold
  always_comb begin
    case (uw.seq)
      SEQ_NEXT:  step_nxt = step_r + 1'b1;
      SEQ_JMP:   step_nxt = uw.target;
      SEQ_JCOND: step_nxt = cond_hit ? uw.target : step_r + 1'b1;
      SEQ_DISPATCH: begin
        case (cmd_r)
          CMD_PROCESS:  step_nxt = ST_B0;
          CMD_DECODED:  step_nxt = ST_C0;
          CMD_RENDERED: step_nxt = ST_G0;
          default:      step_nxt = ST_FIN;
        endcase
      end
      default:   step_nxt = step_r;
    endcase
  end

  // Source and destination lists of a move
  always_comb begin
    mv_en = 1'b0;
    src   = L_FREE;
    dst   = L_READY;
    case (uw.op)
      OP_RELEASE: begin
        mv_en = 1'b1;
        src   = L_BUSY;
        dst   = L_FREE;
      end
      OP_DROP: begin
        mv_en = 1'b1;
        src   = L_READY;
        dst   = L_FREE;
      end
      OP_PRESENT: begin
        mv_en = 1'b1;
        src   = L_READY;
        dst   = L_BUSY;
      end
      OP_ACCEPT: begin
        mv_en = 1'b1;
        src   = L_FREE;
        dst   = L_READY;
      end
      default: begin
        mv_en = 1'b0;
      end
    endcase
    mv_en = mv_en && run_r;
  end

  // Pop the source head and append it to the destination tail in one step.
  always_comb begin
    mv_slot  = '0;
    dst_tail = '0;
    dst_ne   = 1'b0;
    for (int l = 0; l < LIST_N; l++) begin
      if (l == int'(src)) mv_slot = head_r[l];
      if (l == int'(dst)) begin
        dst_tail = tail_r[l];
        dst_ne   = ne_r[l];
      end
    end

    head_nxt = head_r;
    tail_nxt = tail_r;
    len_nxt  = len_r;
    ne_nxt   = ne_r;
    lv_nxt   = lv_r;
    if (mv_en) begin
      lv_nxt[mv_slot] = 1'b0;
      if (dst_ne) lv_nxt[dst_tail] = 1'b1;
      for (int l = 0; l < LIST_N; l++) begin
        if (l == int'(src)) begin
          if (lv_r[mv_slot]) begin
            head_nxt[l] = link_rd;
          end else begin
            ne_nxt[l]   = 1'b0;
            head_nxt[l] = '0;
            tail_nxt[l] = '0;
          end
          if (len_r[l] != '0) len_nxt[l] = len_r[l] - 1'b1;
        end
        if (l == int'(dst)) begin
          if (ne_r[l]) begin
            tail_nxt[l] = mv_slot;
          end else begin
            head_nxt[l] = mv_slot;
            tail_nxt[l] = mv_slot;
            ne_nxt[l]   = 1'b1;
          end
          len_nxt[l] = len_r[l] + 1'b1;
        end
      end
    end
  end

  assign link_we = mv_en && dst_ne;
  assign time_we = run_r && (uw.op == OP_ACCEPT);
  assign vbk_we  = run_r && (uw.op == OP_STAMP);

  // Slot memories: one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (link_we) link_mem[dst_tail] <= mv_slot;
    if (ld_link) begin
      link_q_r      <= link_mem[rd_addr];
      link_wr_q_r   <= lnk_wr_r[rd_addr];
      link_addr_q_r <= rd_addr;
    end
    if (time_we) time_mem[mv_slot] <= ftime_r;
    if (ld_data) time_rd_r <= time_mem[rd_addr];
    if (vbk_we) vbk_mem[cur_r] <= vb_r;
    if (ld_data) begin
      vbk_q_r    <= vbk_mem[rd_addr];
      vbk_wr_q_r <= vbk_wr_r[rd_addr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r   <= MARGIN_RST;
      duration_r <= DURATION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RELEASE_MARGIN: margin_r   <= cfg_data[MARGIN_W-1:0];
        REG_PLAY_DURATION:  duration_r <= cfg_data[TIME_W-1:0];
        default:            ;
      endcase
    end
  end

  // Sequencer, list state and current frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      step_r      <= ST_DISPATCH;
      out_valid_r <= 1'b0;
      // free list holds every slot; ready and busy start empty
      for (int l = 0; l < LIST_N; l++) begin
        head_r[l] <= '0;
        if (l == int'(L_FREE)) begin
          tail_r[l] <= SW'(SLOT_COUNT - 1);
          len_r[l]  <= LW'(SLOT_COUNT);
          ne_r[l]   <= 1'b1;
        end else begin
          tail_r[l] <= '0;
          len_r[l]  <= '0;
          ne_r[l]   <= 1'b0;
        end
      end
      lv_r           <= {1'b0, {(SLOT_COUNT-1){1'b1}}};
      lnk_wr_r       <= '0;
      vbk_wr_r       <= '0;
      cur_r          <= '0;
      cur_v_r        <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (start_acc) begin
        run_r  <= 1'b1;
        step_r <= ST_DISPATCH;
      end else if (run_r) begin
        step_r <= step_nxt;
        if (uw.op == OP_FINISH) begin
          run_r       <= 1'b0;
          out_valid_r <= 1'b1;
        end
      end
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      len_r  <= len_nxt;
      ne_r   <= ne_nxt;
      lv_r   <= lv_nxt;
      if (link_we) lnk_wr_r[dst_tail] <= 1'b1;
      if (vbk_we) vbk_wr_r[cur_r] <= 1'b1;
      if (run_r && (uw.op == OP_PRESENT)) begin
        cur_r   <= mv_slot;
        cur_v_r <= 1'b1;
      end
    end
  end

  // Input word latch and per-word result accumulators
  always_ff @(posedge clk) begin
    if (start_acc) begin
      cmd_r    <= in_command;
      now_r    <= in_current_time;
      vb_r     <= in_vblank_count;
      ftime_r  <= in_frame_time;
      pvalid_r <= 1'b0;
      pslot_r  <= '0;
      drop_r   <= '0;
      rel_r    <= '0;
      acc_r    <= 1'b0;
    end else if (run_r) begin
      case (uw.op)
        OP_RELEASE: rel_r  <= rel_r + 1'b1;
        OP_DROP:    drop_r <= drop_r + 1'b1;
        OP_PRESENT: begin
          pvalid_r <= 1'b1;
          pslot_r  <= mv_slot;
        end
        OP_ACCEPT:  acc_r <= 1'b1;
        default:    ;
      endcase
    end
  end

  // Result word: list status is final once the program has ended.
  assign busy               = run_r;
  assign out_valid          = out_valid_r;
  assign out_present_valid  = pvalid_r;
  assign out_present_slot   = SLOT_OUT_W'(pslot_r);
  assign out_dropped_count  = drop_r;
  assign out_released_count = rel_r;
  assign out_accepted       = acc_r;
  assign out_free_available = ne_r[L_FREE];
  assign out_free_slot      = ne_r[L_FREE] ? SLOT_OUT_W'(head_r[L_FREE]) : '0;
  assign out_ready_count    = COUNT_OUT_W'(len_r[L_READY]);
  assign out_busy_count     = COUNT_OUT_W'(len_r[L_BUSY]);

`ifndef NO_ASSERTIONS
  a_out_ends_program: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(run_r) && !run_r))
    else $error("result word without a finished program");

  a_slots_conserved: assert property (@(posedge clk) disable iff (!rst_n)
    (SUM_W'(len_r[L_FREE]) + SUM_W'(len_r[L_READY]) + SUM_W'(len_r[L_BUSY]))
      == SUM_W'(SLOT_COUNT))
    else $error("slot count across lists changed");

  a_nonempty_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
    (ne_r[L_FREE] == (len_r[L_FREE] != '0)) && (ne_r[L_READY] == (len_r[L_READY] != '0))
      && (ne_r[L_BUSY] == (len_r[L_BUSY] != '0)))
    else $error("list nonempty flag disagrees with length");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && (out_present_valid || out_released_count != '0)))
    else $error("decoded and process results in one word");
`endif

endmodule
